// ===== sv/fpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared widths, command and status codes, and register indexes for the
// FIFO page replacement unit.
// ----------------------------------------------------------------------------
package fpr_pkg;

  // Default number of page frames the resident store can hold
  localparam int MAX_FRAMES_DEF = 16;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int PAGE_W  = 31;
  localparam int SIZE_W  = 16;
  localparam int PS_W    = 16;
  localparam int FC_W    = 5;
  localparam int ST_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Result status
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_SPAN  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOCFG = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd1;

  // Reset value of frame_count
  localparam logic [FC_W-1:0] FC_RESET = 5'd1;

endpackage

// ===== sv/fpr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/fifo_page_replacement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_unit
// Page lookup with FIFO replacement over a small resident page store.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an access beat (cmd, address, access_size) is taken at a
//   clock edge with start high and busy low. busy stays high until the result
//   is produced. Each beat yields exactly one result (status, page_number,
//   was_miss), shown for one cycle with done high; the receiver cannot stall.
//   Config port: cfg_we/cfg_index/cfg_data write page_size (index 0) and
//   frame_count (index 1); write only while busy is low and no result pending.
// Sequence:
//   Unconfigured or empty access: result in the cycle after the accept.
//   Otherwise a bit-serial restoring divider runs, then a span check state
//   that answers spans and queries; reads and writes go on to a scan of the
//   resident pages through the RAM read port, one entry per cycle, a step to
//   compare the last read and a step to leave. A hit ends the scan on its
//   compare cycle. A miss goes on through an evict state and a write state;
//   busy drops with the result, so one beat at a time.
// Reset: rst clears the resident count, oldest slot, page_size (0) and
//   frame_count (1). The page RAM is not cleared; only written slots are compared.
// ----------------------------------------------------------------------------
module fifo_page_replacement_unit
  import fpr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [PAGE_W-1:0]     address,
  input  logic [SIZE_W-1:0]     access_size,
  // result channel
  output logic                  done,
  output logic [ST_W-1:0]       status,
  output logic [PAGE_W-1:0]     page_number,
  output logic                  was_miss,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int DIV_CNT_W = $clog2(PAGE_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PAGE_W - 1);
  localparam logic [CNT_W:0] MAX_EXT = (CNT_W + 1)'(MAX_FRAMES);

  // State codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EVICT = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;

  logic [2:0]           state;
  logic [PS_W-1:0]      page_size;
  logic [FC_W-1:0]      frame_count;
  logic [CNT_W-1:0]     res_count;
  logic [SLOT_W-1:0]    oldest;

  // per-beat working registers
  logic [CMD_W-1:0]     cmd_q;
  logic [SIZE_W-1:0]    size_q;
  logic [PAGE_W-1:0]    dvd;        // dividend in, quotient out
  logic [PS_W-1:0]      rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0]     scan_i;
  logic                 pend;

  // RAM ports
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  logic [SLOT_W-1:0]    rd_addr;
  logic [PAGE_W-1:0]    rd_data;

  // divider step
  logic [PS_W:0]        trial;
  logic                 trial_ge;
  // span check: remainder + size beyond one page
  logic [PS_W:0]        end_off;
  logic                 spans;
  // frame limit and eviction
  logic [CNT_W-1:0]     lim;
  logic                 full;
  logic [CNT_W-1:0]     evict_n;

  // Wrap a slot sum back into 0..MAX_FRAMES-1 (sum stays below twice the depth)
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] s);
    if (s >= MAX_EXT) begin
      return SLOT_W'(s - MAX_EXT);
    end else begin
      return SLOT_W'(s);
    end
  endfunction

  assign busy = (state != S_IDLE);

  assign trial    = {rem, dvd[PAGE_W-1]};
  assign trial_ge = (trial >= {1'b0, page_size});
  assign end_off  = {1'b0, rem} + {1'b0, size_q};
  assign spans    = (end_off > {1'b0, page_size});

  // Clamp frame_count into 1..MAX_FRAMES
  always_comb begin
    priority if (frame_count == '0) begin
      lim = CNT_W'(1);
    end else if (32'(frame_count) > 32'(MAX_FRAMES)) begin
      lim = CNT_W'(MAX_FRAMES);
    end else begin
      lim = CNT_W'(frame_count);
    end
  end

  assign full    = (res_count >= lim);
  assign evict_n = res_count - lim + CNT_W'(1);

  // Read address walks from the oldest slot; write lands after the newest
  assign rd_addr = wrap_slot((CNT_W + 1)'(oldest) + (CNT_W + 1)'(scan_i));
  assign wr_addr = wrap_slot((CNT_W + 1)'(oldest) + (CNT_W + 1)'(res_count));
  assign wr_en   = (state == S_LOAD);

  // Page store; beats never overlap, so a write always precedes later reads
  fpr_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (MAX_FRAMES)
  ) u_pages (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (dvd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size   <= '0;
      frame_count <= FC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAGE_SIZE:   page_size   <= cfg_data[PS_W-1:0];
        REG_FRAME_COUNT: frame_count <= cfg_data[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      res_count <= '0;
      oldest    <= '0;
      pend      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd;
            size_q  <= access_size;
            dvd     <= address;
            rem     <= '0;
            div_cnt <= '0;
            priority if (page_size == '0) begin
              done        <= 1'b1;
              status      <= ST_NOCFG;
              page_number <= '0;
              was_miss    <= 1'b0;
            end else if (access_size == '0) begin
              done        <= 1'b1;
              status      <= ST_SPAN;
              page_number <= '0;
              was_miss    <= 1'b0;
            end else begin
              state <= S_DIV;
            end
          end
        end

        // one quotient bit per cycle
        S_DIV: begin
          rem     <= trial_ge ? PS_W'(trial - {1'b0, page_size}) : trial[PS_W-1:0];
          dvd     <= {dvd[PAGE_W-2:0], trial_ge};
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_LAST) begin
            state <= S_CHK;
          end
        end

        S_CHK: begin
          scan_i <= '0;
          pend   <= 1'b0;
          if (spans) begin
            done        <= 1'b1;
            status      <= ST_SPAN;
            page_number <= '0;
            was_miss    <= 1'b0;
            state       <= S_IDLE;
          end else if (cmd_q == CMD_READ || cmd_q == CMD_WRITE) begin
            state <= S_SCAN;
          end else begin
            done        <= 1'b1;
            status      <= ST_OK;
            page_number <= dvd;
            was_miss    <= 1'b0;
            state       <= S_IDLE;
          end
        end

        // issue one read per cycle, compare the entry read the cycle before
        S_SCAN: begin
          priority if (pend && rd_data == dvd) begin
            done        <= 1'b1;
            status      <= ST_OK;
            page_number <= dvd;
            was_miss    <= 1'b0;
            pend        <= 1'b0;
            state       <= S_IDLE;
          end else if (scan_i < res_count) begin
            scan_i <= scan_i + CNT_W'(1);
            pend   <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            state <= S_EVICT;
          end
        end

        // drop oldest pages until one frame is free
        S_EVICT: begin
          if (full) begin
            oldest    <= wrap_slot((CNT_W + 1)'(oldest) + (CNT_W + 1)'(evict_n));
            res_count <= lim - CNT_W'(1);
          end
          state <= S_LOAD;
        end

        S_LOAD: begin
          res_count   <= res_count + CNT_W'(1);
          done        <= 1'b1;
          status      <= ST_OK;
          page_number <= dvd;
          was_miss    <= 1'b1;
          state       <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/fpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks on the FIFO page replacement unit, bound to the top.
// ----------------------------------------------------------------------------
module fpr_checker
  import fpr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [ST_W-1:0]   status,
  input logic [PAGE_W-1:0] page_number,
  input logic              was_miss
);

  // A taken beat is either being worked on or answered next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat neither busy nor answered");

  // A failed beat reports no page and no miss
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (page_number == '0 && !was_miss))
    else $error("error result carries page or miss");

  // A result only closes a beat: busy drops with the result
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // Status code is one of the defined ones
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_SPAN || status == ST_NOCFG))
    else $error("undefined status code");

  // Nothing is pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (!busy && !done))
    else $error("activity right after reset");

endmodule

bind fifo_page_replacement_unit fpr_checker u_fpr_checker (.*);
